[rtl/string_hash_table_insert_lookup_core_defines.svh]
// Assertion macros shared by the RTL. Synthesis builds see empty bodies.
`ifndef STRING_HASH_TABLE_INSERT_LOOKUP_CORE_DEFINES_SVH
`define STRING_HASH_TABLE_INSERT_LOOKUP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define SHTIL_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define SHTIL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define SHTIL_ASSERT_SAME(label, clk, rst, ante, cons)
`define SHTIL_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/shtil_pkg.sv]
`timescale 1ns / 1ps
package shtil_pkg;

   // Slot table geometry. The size is a power of two, so the home slot is
   // the low bits of the position hash.
   localparam int TABLE_SIZE   = 1024;
   localparam int SLOT_W       = $clog2(TABLE_SIZE);
   localparam int SLOT_INDEX_W = 10;

   localparam int HASH_W     = 32;
   localparam int HASH_COUNT = 3;
   localparam int KEY_W      = 2 * HASH_W;
   localparam int CHAR_W     = 8;

   // Stream widths.
   localparam int REQ_TDATA_W = 8;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 16;
   localparam int RSP_TUSER_W = 2;
   localparam int USER_MODE_BIT    = 0;
   localparam int USER_PRESENT_BIT = 1;

   // Job queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;

   // Running seed reset values.
   localparam logic [HASH_W-1:0] SEED_ONE_INIT = 32'h7FED7FED;
   localparam logic [HASH_W-1:0] SEED_TWO_INIT = 32'hEEEEEEEE;

   // Crypt table generator.
   localparam int                CRYPT_COLS = 256;
   localparam int                CRYPT_ROWS = 5;
   localparam logic [HASH_W-1:0] CRYPT_SEED = 32'h00100001;
   localparam logic [HASH_W-1:0] CRYPT_MUL  = 32'd125;
   localparam logic [HASH_W-1:0] CRYPT_ADD  = 32'd3;
   localparam logic [HASH_W-1:0] CRYPT_MOD  = 32'h002AAAAB;

   typedef enum logic {
      MODE_LOOKUP = 1'b0,
      MODE_INSERT = 1'b1
   } mode_type;

   typedef enum logic [1:0] {
      RES_INSERTED  = 2'd0,
      RES_FULL      = 2'd1,
      RES_FOUND     = 2'd2,
      RES_NOT_FOUND = 2'd3
   } result_code_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MIX,
      F_PUSH
   } f_state_type;

   typedef enum logic [1:0] {
      B_CLEAR,
      B_IDLE,
      B_PROBE
   } b_state_type;

   typedef struct packed {
      mode_type           mode;
      logic [SLOT_W-1:0]  start;
      logic [KEY_W-1:0]   key;
   } job_type;

   typedef logic [HASH_COUNT-1:0][CRYPT_COLS-1:0][HASH_W-1:0] crypt_table_type;

   // Only the first three rows of the generated table are ever used, but the
   // generator still has to step through all five to stay in sequence.
   function automatic crypt_table_type build_crypt_table();
      crypt_table_type   t;
      logic [HASH_W-1:0] s;
      logic [HASH_W-1:0] hi;
      logic [HASH_W-1:0] lo;
      t = '0;
      s = CRYPT_SEED;
      for (int col = 0; col < CRYPT_COLS; col++) begin
         for (int row = 0; row < CRYPT_ROWS; row++) begin
            s  = (s * CRYPT_MUL + CRYPT_ADD) % CRYPT_MOD;
            hi = {s[15:0], 16'h0000};
            s  = (s * CRYPT_MUL + CRYPT_ADD) % CRYPT_MOD;
            lo = {16'h0000, s[15:0]};
            if (row < HASH_COUNT) begin
               t[row][col] = hi | lo;
            end
         end
      end
      return t;
   endfunction

   localparam crypt_table_type CRYPT_TABLE = build_crypt_table();

endpackage

[rtl/shtil_ram.sv]
`timescale 1ns / 1ps
module shtil_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/shtil_front.sv]
`timescale 1ns / 1ps
module shtil_front import shtil_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [REQ_TUSER_W-1:0] req_tuser,
   input  logic                   req_tlast,
   input  logic                   clearing,
   output logic                   push_valid,
   input  logic                   push_ready,
   output job_type                push_job
);

   f_state_type       state_ff, state_in;
   logic [HASH_W-1:0] seed_a_ff [HASH_COUNT];
   logic [HASH_W-1:0] seed_a_in [HASH_COUNT];
   logic [HASH_W-1:0] seed_b_ff [HASH_COUNT];
   logic [HASH_W-1:0] seed_b_in [HASH_COUNT];
   logic [HASH_W-1:0] mixed_a   [HASH_COUNT];
   logic [HASH_W-1:0] mixed_b   [HASH_COUNT];
   logic [CHAR_W-1:0] char_ff, char_in;
   logic [CHAR_W-1:0] upper_char;
   logic              last_ff, last_in;
   mode_type          mode_ff, mode_in;

   // Only ASCII a..z are folded to upper case.
   assign upper_char = (req_tdata >= 8'h61 && req_tdata <= 8'h7A) ?
                       req_tdata - 8'h20 : req_tdata;

   // The seed-one update uses the incoming byte; the seed-two update uses the
   // byte held from the previous cycle and the freshly updated seed one.
   always_comb begin
      for (int k = 0; k < HASH_COUNT; k++) begin
         mixed_a[k] = CRYPT_TABLE[k][upper_char] ^ (seed_a_ff[k] + seed_b_ff[k]);
         mixed_b[k] = HASH_W'(char_ff) + seed_a_ff[k] + seed_b_ff[k]
                    + {seed_b_ff[k][HASH_W-6:0], 5'b00000} + HASH_W'(3);
      end
   end

   always_comb begin
      state_in   = state_ff;
      seed_a_in  = seed_a_ff;
      seed_b_in  = seed_b_ff;
      char_in    = char_ff;
      last_in    = last_ff;
      mode_in    = mode_ff;
      req_tready = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            req_tready = !clearing;
            if (req_tvalid && !clearing) begin
               mode_in = mode_type'(req_tuser[USER_MODE_BIT]);
               last_in = req_tlast;
               char_in = upper_char;
               if (req_tuser[USER_PRESENT_BIT]) begin
                  seed_a_in = mixed_a;
                  state_in  = F_MIX;
               end else if (req_tlast) begin
                  state_in = F_PUSH;
               end
            end
         end
         F_MIX: begin
            if (last_ff) begin
               // Seed two is not needed for the job and is reset anyway.
               push_valid = 1'b1;
               if (push_ready) begin
                  for (int k = 0; k < HASH_COUNT; k++) begin
                     seed_a_in[k] = SEED_ONE_INIT;
                     seed_b_in[k] = SEED_TWO_INIT;
                  end
                  state_in = F_IDLE;
               end else begin
                  state_in = F_PUSH;
               end
            end else begin
               seed_b_in = mixed_b;
               state_in  = F_IDLE;
            end
         end
         F_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               for (int k = 0; k < HASH_COUNT; k++) begin
                  seed_a_in[k] = SEED_ONE_INIT;
                  seed_b_in[k] = SEED_TWO_INIT;
               end
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         for (int k = 0; k < HASH_COUNT; k++) begin
            seed_a_ff[k] <= SEED_ONE_INIT;
            seed_b_ff[k] <= SEED_TWO_INIT;
         end
      end else begin
         state_ff  <= state_in;
         seed_a_ff <= seed_a_in;
         seed_b_ff <= seed_b_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff <= char_in;
      last_ff <= last_in;
      mode_ff <= mode_in;
   end

   assign push_job.mode  = mode_ff;
   assign push_job.start = seed_a_ff[0][SLOT_W-1:0];
   assign push_job.key   = {seed_a_ff[1], seed_a_ff[2]};

endmodule

[rtl/shtil_queue.sv]
`timescale 1ns / 1ps
module shtil_queue import shtil_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop_ready,
   output job_type pop_job
);

   localparam int PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int COUNT_W = $clog2(QUEUE_DEPTH + 1);

   job_type            entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               do_push;
   logic               do_pop;

   assign push_ready = count_ff != COUNT_W'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign pop_job    = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - COUNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

[rtl/shtil_back.sv]
`timescale 1ns / 1ps
module shtil_back import shtil_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  job_type                pop_job,
   output logic                   clearing,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic [RSP_TUSER_W-1:0] rsp_tuser
);

   b_state_type       state_ff, state_in;
   logic [SLOT_W-1:0] clr_ff, clr_in;
   logic [SLOT_W-1:0] pos_ff, pos_in;
   logic [SLOT_W-1:0] cnt_ff, cnt_in;
   job_type           job_ff, job_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_code_type   code_ff, code_in;
   logic [SLOT_W-1:0] idx_ff, idx_in;

   logic [SLOT_W-1:0] rd_addr;
   logic              valid_we;
   logic [SLOT_W-1:0] valid_wa;
   logic [0:0]        valid_wd;
   logic [0:0]        valid_rd;
   logic              check_we;
   logic [KEY_W-1:0]  check_rd;
   logic              last_probe;
   logic              done;

   // Valid bits live in their own memory so that only they are swept after
   // reset; check words are written by inserts alone.
   shtil_ram #(
      .WIDTH (1),
      .DEPTH (TABLE_SIZE)
   ) u_valid_ram (
      .clock   (clock),
      .wr_en   (valid_we),
      .wr_addr (valid_wa),
      .wr_data (valid_wd),
      .rd_addr (rd_addr),
      .rd_data (valid_rd)
   );

   shtil_ram #(
      .WIDTH (KEY_W),
      .DEPTH (TABLE_SIZE)
   ) u_check_ram (
      .clock   (clock),
      .wr_en   (check_we),
      .wr_addr (pos_ff),
      .wr_data (job_ff.key),
      .rd_addr (rd_addr),
      .rd_data (check_rd)
   );

   assign last_probe = cnt_ff == SLOT_W'(TABLE_SIZE - 1);

   // While a slot is judged, the next slot is already being read, so the
   // walk covers one slot per cycle.
   always_comb begin
      state_in  = state_ff;
      clr_in    = clr_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      job_in    = job_ff;
      code_in   = code_ff;
      idx_in    = idx_ff;
      rd_addr   = pos_ff + SLOT_W'(1);
      valid_we  = 1'b0;
      valid_wa  = pos_ff;
      valid_wd  = 1'b1;
      check_we  = 1'b0;
      pop_ready = 1'b0;
      clearing  = 1'b0;
      done      = 1'b0;
      unique case (state_ff)
         B_CLEAR: begin
            clearing = 1'b1;
            valid_we = 1'b1;
            valid_wa = clr_ff;
            valid_wd = 1'b0;
            clr_in   = clr_ff + SLOT_W'(1);
            if (clr_ff == SLOT_W'(TABLE_SIZE - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            rd_addr   = pop_job.start;
            pop_ready = !rsp_valid_ff || rsp_tready;
            if (pop_valid && pop_ready) begin
               job_in   = pop_job;
               pos_in   = pop_job.start;
               cnt_in   = '0;
               state_in = B_PROBE;
            end
         end
         B_PROBE: begin
            if (job_ff.mode == MODE_INSERT) begin
               if (!valid_rd[0]) begin
                  valid_we = 1'b1;
                  check_we = 1'b1;
                  done     = 1'b1;
                  code_in  = RES_INSERTED;
                  idx_in   = pos_ff;
               end else if (last_probe) begin
                  done    = 1'b1;
                  code_in = RES_FULL;
                  idx_in  = '0;
               end
            end else begin
               if (!valid_rd[0]) begin
                  done    = 1'b1;
                  code_in = RES_NOT_FOUND;
                  idx_in  = '0;
               end else if (check_rd == job_ff.key) begin
                  done    = 1'b1;
                  code_in = RES_FOUND;
                  idx_in  = pos_ff;
               end else if (last_probe) begin
                  done    = 1'b1;
                  code_in = RES_NOT_FOUND;
                  idx_in  = '0;
               end
            end
            if (done) begin
               state_in = B_IDLE;
            end else begin
               pos_in = pos_ff + SLOT_W'(1);
               cnt_in = cnt_ff + SLOT_W'(1);
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
      rsp_valid_in = done || (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff  <= pos_in;
      cnt_ff  <= cnt_in;
      job_ff  <= job_in;
      code_ff <= code_in;
      idx_ff  <= idx_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = code_ff;
   assign rsp_tdata  = RSP_TDATA_W'(SLOT_INDEX_W'(idx_ff));

endmodule

[rtl/string_hash_table_insert_lookup_core.sv]
`timescale 1ns / 1ps
// String hash table with insert and lookup. A string arrives on the req
// channel one beat per byte: req_tdata carries the byte, req_tuser[0] the
// mode (0 lookup, 1 insert, taken from the final beat), req_tuser[1] says
// the byte is real, and req_tlast marks the final beat. An empty string is
// sent as a single final beat with req_tuser[1] low.
// Each real byte is upper-cased and folded into three crypt-table hashes in
// the F_IDLE and F_MIX states, and the front takes no new beat until both
// are done. The final beat hands its job to a two-entry queue from F_MIX, a
// bare final marker from F_PUSH, and the front waits in F_PUSH while the
// queue is full, then takes the next string. The back walks the slot
// memory from the home slot, one slot per cycle after the home slot is read
// in B_IDLE, and a full wrap of the table probes all 1024 slots. The result
// is one rsp beat from the back's output register: rsp_tuser the code,
// rsp_tdata the slot. A stalled rsp channel holds the result in its output
// register; the back then stops taking jobs, the queue fills and the front
// stalls req. After reset the valid bits of all 1024 slots are swept, one
// per cycle, and req_tready stays low until the sweep is done.
`include "string_hash_table_insert_lookup_core_defines.svh"
module string_hash_table_insert_lookup_core import shtil_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // character
   input  logic [REQ_TUSER_W-1:0] req_tuser,  // mode, char_present
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // slot_index, zero fill
   output logic [RSP_TUSER_W-1:0] rsp_tuser   // result_code
);

   logic    clearing;
   logic    push_valid;
   logic    push_ready;
   job_type push_job;
   logic    pop_valid;
   logic    pop_ready;
   job_type pop_job;

   // Front: byte intake, case folding and hashing.
   shtil_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job)
   );

   // Finished hashes wait here so the front can start the next string.
   shtil_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // Back: slot memory, clearing sweep, linear probing and result register.
   shtil_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job),
      .clearing   (clearing),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // No string may enter or leave the front while the valid bits are swept.
   `SHTIL_ASSERT_SAME(a_no_req_in_clear, clock, reset, clearing, !req_tready)
   `SHTIL_ASSERT_SAME(a_no_push_in_clear, clock, reset, clearing, !push_valid)
   // A job is only started when the result register is free or draining.
   `SHTIL_ASSERT_NEXT(a_pop_frees_rsp, clock, reset, pop_valid && pop_ready, !rsp_tvalid)
   // Misses and full tables report slot zero.
   `SHTIL_ASSERT_SAME(a_miss_index_zero, clock, reset,
      rsp_tvalid && (rsp_tuser == RES_FULL || rsp_tuser == RES_NOT_FOUND), rsp_tdata == '0)

endmodule
